// File: rtl/psg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants and types for the Plummer softened gravity pipeline.
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAV = 2'd0,
    REG_MASS = 2'd1,
    REG_SOFT = 2'd2
  } cfg_idx_e;

endpackage

// File: rtl/psg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients of 2^QW and above. All stages hold while en_i is low.
// ----------------------------------------------------------------------------
module psg_div import psg_pkg::*; #(
  parameter int QW = COORD_WIDTH_DEF,
  parameter int NW = 2 * COORD_WIDTH_DEF,
  parameter int DW = COORD_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int CMPW = (NW > DW) ? NW : DW;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] dn_q  [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ov_q  [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      dn_q[0]  <= den_i;
      q_q[0]   <= '0;
      ov_q[0]  <= CMPW'(num_i >> QW) >= CMPW'(den_i);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic take;
    assign take = CMPW'(rem_q[k] >> B) >= CMPW'(dn_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? rem_q[k] - (NW'(dn_q[k]) << B) : rem_q[k];
        dn_q[k+1]  <= dn_q[k];
        q_q[k+1]   <= take ? (q_q[k] | (QW'(1) << B)) : q_q[k];
        ov_q[k+1]  <= ov_q[k];
      end
    end
  end

  assign quo_o = q_q[QW];
  assign ovf_o = ov_q[QW];

endmodule

// File: rtl/plummer_softened_gravity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plummer_softened_gravity
// Potential -G*m/sqrt(s) and gradient G*m*(x,y,z)/s^1.5 of a Plummer sphere,
// s = x^2+y^2+z^2+b^2, fixed point, truncated toward zero and saturated.
//
//   channel  signals                               direction
//   in       in_valid_i/in_ready_o, pos_*_i        to block
//   out      out_valid_o/out_ready_i, results      from block
//   cfg      cfg_valid_i/cfg_ready_o, index, data  to block
//
// One beat per cycle while the skid is empty. The pipeline runs through the
// input stages, the square root stages (one root bit each, RW of them), the
// dividers (one quotient bit each) and the output register. Reset clears the
// pipeline and loads the registers with 1.0. A stalled output fills a
// one-beat skid, after which the whole pipeline holds.
// ----------------------------------------------------------------------------
module plummer_softened_gravity import psg_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] potential_o,
  output logic signed [COORD_WIDTH-1:0] grad_x_o,
  output logic signed [COORD_WIDTH-1:0] grad_y_o,
  output logic signed [COORD_WIDTH-1:0] grad_z_o,
  output logic                          saturated_o,
  output logic                          div_by_zero_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int CW   = CFG_W;
  localparam int HW   = CW;
  localparam int SQW  = 2 * W;
  localparam int BQW  = 2 * CW;
  localparam int SMX  = (SQW > BQW) ? SQW : BQW;
  localparam int SW   = SMX + 2;
  localparam int RW   = (SW + 2 * F + 1) / 2;
  localparam int TW   = 2 * RW;
  localparam int XW   = TW + 2;
  localparam int GMW  = 2 * CW;
  localparam int AW   = GMW + W;
  localparam int GNW  = AW + 2 * F;
  localparam int DDW  = SW + RW;
  localparam int PNW  = GMW + F;
  localparam int DL   = W + 1;
  localparam int RSW  = 4 * W + 2;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  logic ov_q, sk_v_q;
  logic en;
  assign en = !sk_v_q;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration
  logic [CW-1:0] grav_q, mass_q, soft_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= CW'(65536);
      mass_q <= CW'(65536);
      soft_q <= CW'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_GRAV: grav_q <= cfg_data_i;
        REG_MASS: mass_q <= cfg_data_i;
        REG_SOFT: soft_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: magnitudes, G*m
  logic [W-1:0] pos_d [3];
  logic [W-1:0] mag_d [3];
  logic [2:0]   neg_d;
  always_comb begin
    pos_d[0] = pos_x_i;
    pos_d[1] = pos_y_i;
    pos_d[2] = pos_z_i;
    for (int j = 0; j < 3; j++) begin
      neg_d[j] = pos_d[j][W-1];
      mag_d[j] = neg_d[j] ? (~pos_d[j] + 1'b1) : pos_d[j];
    end
  end

  logic           v1_q, v2_q, v3_q;
  logic [W-1:0]   mag1_q [3];
  logic [2:0]     neg1_q, neg2_q, neg3_q;
  logic [GMW-1:0] gm1_q, gm2_q, gm3_q;
  logic [CW-1:0]  b1_q;
  logic [SQW-1:0] sq2_q [3];
  logic [BQW-1:0] bsq2_q;
  logic [HW+W-1:0] plo2_q [3];
  logic [HW+W-1:0] phi2_q [3];
  logic [SW-1:0]  s3_q;
  logic [AW-1:0]  a3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= mag_d;
      neg1_q <= neg_d;
      gm1_q  <= GMW'(grav_q) * GMW'(mass_q);
      b1_q   <= soft_q;
      // stage 2: squares and partial products of G*m*|a|
      for (int j = 0; j < 3; j++) begin
        sq2_q[j]  <= SQW'(mag1_q[j]) * SQW'(mag1_q[j]);
        plo2_q[j] <= (HW+W)'(gm1_q[HW-1:0]) * (HW+W)'(mag1_q[j]);
        phi2_q[j] <= (HW+W)'(gm1_q[GMW-1:HW]) * (HW+W)'(mag1_q[j]);
      end
      bsq2_q <= BQW'(b1_q) * BQW'(b1_q);
      gm2_q  <= gm1_q;
      neg2_q <= neg1_q;
      // stage 3: sum of squares, G*m*|a|
      s3_q <= SW'(sq2_q[0]) + SW'(sq2_q[1]) + SW'(sq2_q[2]) + SW'(bsq2_q);
      for (int j = 0; j < 3; j++) begin
        a3_q[j] <= AW'(plo2_q[j]) + (AW'(phi2_q[j]) << HW);
      end
      gm3_q  <= gm2_q;
      neg3_q <= neg2_q;
    end
  end

  // root stages: R = isqrt(S << 2F), with S*R accumulated on the way
  logic           sv_q   [1:RW];
  logic [TW-1:0]  srem_q [1:RW];
  logic [RW-1:0]  sres_q [1:RW];
  logic [DDW-1:0] sacc_q [1:RW];
  logic [SW-1:0]  ss_q   [1:RW];
  logic [AW-1:0]  sa_q   [1:RW][3];
  logic [GMW-1:0] sgm_q  [1:RW];
  logic [2:0]     sneg_q [1:RW];
  logic           sz_q   [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int B = RW - 1 - k;
    logic           cv, cz, take;
    logic [TW-1:0]  crem;
    logic [RW-1:0]  cres;
    logic [DDW-1:0] cacc;
    logic [SW-1:0]  cs;
    logic [AW-1:0]  ca [3];
    logic [GMW-1:0] cgm;
    logic [2:0]     cneg;
    logic [XW-1:0]  trial;

    if (k == 0) begin : g_head
      assign cv   = v3_q;
      assign crem = TW'(s3_q) << (2 * F);
      assign cres = '0;
      assign cacc = '0;
      assign cs   = s3_q;
      assign ca   = a3_q;
      assign cgm  = gm3_q;
      assign cneg = neg3_q;
      assign cz   = (s3_q == '0);
    end else begin : g_body
      assign cv   = sv_q[k];
      assign crem = srem_q[k];
      assign cres = sres_q[k];
      assign cacc = sacc_q[k];
      assign cs   = ss_q[k];
      assign ca   = sa_q[k];
      assign cgm  = sgm_q[k];
      assign cneg = sneg_q[k];
      assign cz   = sz_q[k];
    end

    assign trial = (XW'(cres) << (B + 1)) + (XW'(1) << (2 * B));
    assign take  = XW'(crem) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        srem_q[k+1] <= take ? crem - TW'(trial) : crem;
        sres_q[k+1] <= take ? (cres | (RW'(1) << B)) : cres;
        sacc_q[k+1] <= take ? cacc + (DDW'(cs) << B) : cacc;
        ss_q[k+1]   <= cs;
        sa_q[k+1]   <= ca;
        sgm_q[k+1]  <= cgm;
        sneg_q[k+1] <= cneg;
        sz_q[k+1]   <= cz;
      end
    end
  end

  // dividers
  logic [W-1:0] quo [4];
  logic [3:0]   ovf;

  psg_div #(.QW(W), .NW(PNW), .DW(RW)) u_div_pot (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (PNW'(sgm_q[RW]) << F),
    .den_i (sres_q[RW]),
    .quo_o (quo[0]),
    .ovf_o (ovf[0])
  );

  for (genvar j = 0; j < 3; j++) begin : g_grad
    psg_div #(.QW(W), .NW(GNW), .DW(DDW)) u_div_grad (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (GNW'(sa_q[RW][j]) << (2 * F)),
      .den_i (sacc_q[RW]),
      .quo_o (quo[j+1]),
      .ovf_o (ovf[j+1])
    );
  end

  logic       dv_q   [1:DL];
  logic [2:0] dneg_q [1:DL];
  logic       dz_q   [1:DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= DL; k++) dv_q[k] <= 1'b0;
    end else if (en) begin
      dv_q[1] <= sv_q[RW];
      for (int k = 2; k <= DL; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dneg_q[1] <= sneg_q[RW];
      dz_q[1]   <= sz_q[RW];
      for (int k = 2; k <= DL; k++) begin
        dneg_q[k] <= dneg_q[k-1];
        dz_q[k]   <= dz_q[k-1];
      end
    end
  end

  // sign, saturation, zero
  logic [3:0]     lneg, clip;
  logic [W-1:0]   lim [4];
  logic [W-1:0]   mv  [4];
  logic [W-1:0]   val [4];
  logic [RSW-1:0] res_d;

  always_comb begin
    lneg = {dneg_q[DL], 1'b1};
    for (int j = 0; j < 4; j++) begin
      lim[j]  = lneg[j] ? HALF : HALF - 1'b1;
      clip[j] = ovf[j] || (quo[j] > lim[j]);
      mv[j]   = clip[j] ? lim[j] : quo[j];
      val[j]  = dz_q[DL] ? '0 : (lneg[j] ? (~mv[j] + 1'b1) : mv[j]);
    end
    res_d = {dz_q[DL], !dz_q[DL] && (|clip), val[3], val[2], val[1], val[0]};
  end

  // output register and skid
  logic [RSW-1:0] res_q, sk_q;
  logic           last_v;
  assign last_v = en && dv_q[DL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      sk_v_q <= 1'b0;
    end else if (!ov_q || out_ready_i) begin
      ov_q   <= sk_v_q || last_v;
      sk_v_q <= 1'b0;
    end else if (last_v) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready_i) begin
      res_q <= sk_v_q ? sk_q : res_d;
    end else if (last_v) begin
      sk_q <= res_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign potential_o   = res_q[W-1:0];
  assign grad_x_o      = res_q[2*W-1:W];
  assign grad_y_o      = res_q[3*W-1:2*W];
  assign grad_z_o      = res_q[4*W-1:3*W];
  assign saturated_o   = res_q[4*W];
  assign div_by_zero_o = res_q[4*W+1];

endmodule

// File: rtl/psg_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_chk
// Port-level checks for the Plummer softened gravity block, bound to the top.
// ----------------------------------------------------------------------------
module psg_chk import psg_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [COORD_WIDTH-1:0] potential_o,
  input logic signed [COORD_WIDTH-1:0] grad_x_o,
  input logic signed [COORD_WIDTH-1:0] grad_y_o,
  input logic signed [COORD_WIDTH-1:0] grad_z_o,
  input logic                          saturated_o,
  input logic                          div_by_zero_o
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(potential_o)
      && $stable(grad_x_o) && $stable(div_by_zero_o))
    else $error("output beat changed while stalled");

  // full skid implies full output register
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_by_zero_o |-> potential_o == '0 && grad_x_o == '0
      && grad_y_o == '0 && grad_z_o == '0 && !saturated_o)
    else $error("nonzero result with zero denominator");

  a_pot_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> potential_o[COORD_WIDTH-1] || potential_o == '0)
    else $error("positive potential");

endmodule

bind plummer_softened_gravity psg_chk #(.COORD_WIDTH(COORD_WIDTH)) u_psg_chk (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for plummer_softened_gravity. A bursty driver feeds position beats
// from a queue. A bit-exact model predicts potential, gradient and flags per
// beat. A stalling monitor checks each result beat in order. Registers are
// rewritten between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import psg_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LAT = CW + 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pos_t;
  typedef struct packed {
    coord_t pot;
    coord_t gx;
    coord_t gy;
    coord_t gz;
    logic   sat;
    logic   dz;
  } field_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  coord_t potential_o, grad_x_o, grad_y_o, grad_z_o;
  logic saturated_o, div_by_zero_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  plummer_softened_gravity DUT (.*);

  pos_t   pos_q[$];
  field_t field_q[$];
  logic [CFG_W-1:0] g_reg = 32'd65536, m_reg = 32'd65536, b_reg = 32'd65536;
  int err_cnt = 0, res_cnt = 0, dz_cnt = 0, sat_cnt = 0, acc_cnt = 0;
  int burst_left = 0, gap_left = 0;
  int hold_left = 0, cyc = 0;
  logic long_hold_done = 1'b0, stall_mode = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic coord_t clamp_mag(bit [255:0] mag, bit neg, inout bit sat);
    bit [255:0] lim;
    lim = neg ? (256'd1 << (CW - 1)) : (256'd1 << (CW - 1)) - 1;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? coord_t'(-mag[CW-1:0]) : coord_t'(mag[CW-1:0]);
  endfunction

  function automatic field_t plummer_eval(pos_t p);
    field_t r;
    bit [255:0] mag[3], s, rad, root, cand, gm, den;
    bit neg[3];
    bit sat;
    coord_t c[3];
    r = '0;
    sat = 1'b0;
    c[0] = p.x;
    c[1] = p.y;
    c[2] = p.z;
    s = 256'(b_reg) * 256'(b_reg);
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][CW-1];
      mag[i] = {{(256-CW){1'b0}}, (neg[i] ? -c[i] : c[i])};
      s += mag[i] * mag[i];
    end
    if (s == 0) begin
      r.dz = 1'b1;
      return r;
    end
    rad = s << (2 * FB);
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = root | (256'd1 << i);
      if (cand * cand <= rad) root = cand;
    end
    gm = 256'(g_reg) * 256'(m_reg);
    r.pot = clamp_mag((gm << FB) / root, 1'b1, sat);
    den = s * root;
    r.gx = clamp_mag(((gm * mag[0]) << (2 * FB)) / den, neg[0], sat);
    r.gy = clamp_mag(((gm * mag[1]) << (2 * FB)) / den, neg[1], sat);
    r.gz = clamp_mag(((gm * mag[2]) << (2 * FB)) / den, neg[2], sat);
    r.sat = sat;
    return r;
  endfunction

  // input driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        field_q.push_back(plummer_eval('{pos_x_i, pos_y_i, pos_z_i}));
        acc_cnt++;
      end
      if (gap_left > 0 || pos_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        pos_t p;
        p = pos_q.pop_front();
        in_valid_i <= 1'b1;
        pos_x_i <= p.x;
        pos_y_i <= p.y;
        pos_z_i <= p.z;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cyc++;
      if (out_valid_o && out_ready_i) begin
        if (field_q.size() == 0) begin
          $error("result beat with no expectation");
          err_cnt++;
        end else begin
          field_t e;
          e = field_q.pop_front();
          res_cnt++;
          if (e.dz) dz_cnt++;
          if (e.sat) sat_cnt++;
          if (potential_o !== e.pot) begin
            $error("potential exp %h got %h", e.pot, potential_o); err_cnt++;
          end
          if (grad_x_o !== e.gx) begin
            $error("grad_x exp %h got %h", e.gx, grad_x_o); err_cnt++;
          end
          if (grad_y_o !== e.gy) begin
            $error("grad_y exp %h got %h", e.gy, grad_y_o); err_cnt++;
          end
          if (grad_z_o !== e.gz) begin
            $error("grad_z exp %h got %h", e.gz, grad_z_o); err_cnt++;
          end
          if (saturated_o !== e.sat) begin
            $error("saturated exp %b got %b", e.sat, saturated_o); err_cnt++;
          end
          if (div_by_zero_o !== e.dz) begin
            $error("div_by_zero exp %b got %b", e.dz, div_by_zero_o); err_cnt++;
          end
        end
      end
      if (cyc % 64 == 0) stall_mode = 1'($urandom_range(0, 1));
      if (!long_hold_done && acc_cnt >= 210) begin
        long_hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  task automatic drain();
    do @(posedge clk_i);
    while (pos_q.size() != 0 || in_valid_i || field_q.size() != 0);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_GRAV: g_reg = val;
      REG_MASS: m_reg = val;
      REG_SOFT: b_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [CFG_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'd65536;
      3: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return coord_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      8: return '0;
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b0, {(CW-1){1'b1}}};
          1: return {1'b1, {(CW-1){1'b0}}};
          2: return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  initial begin
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    pos_q.push_back('{0, 0, 0});
    pos_q.push_back('{mx, mx, mx});
    pos_q.push_back('{mn, mn, mn});
    pos_q.push_back('{mx, mn, 0});
    pos_q.push_back('{1, -1, 0});
    pos_q.push_back('{32'sh10000, 0, 0});
    pos_q.push_back('{0, -32'sh10000, 32'sh8000});
    drain();

    cfg_write(REG_SOFT, '0);
    cfg_write(REG_UNUSED, 32'h1234_5678);
    pos_q.push_back('{0, 0, 0});
    pos_q.push_back('{1, 0, 0});
    pos_q.push_back('{0, -1, 0});
    pos_q.push_back('{0, 0, mn});
    pos_q.push_back('{mx, 0, 0});
    drain();

    cfg_write(REG_GRAV, '1);
    cfg_write(REG_MASS, '1);
    pos_q.push_back('{0, 0, 0});
    pos_q.push_back('{mx, mn, mx});
    pos_q.push_back('{1, 1, 1});
    drain();

    cfg_write(REG_GRAV, '0);
    cfg_write(REG_SOFT, '1);
    pos_q.push_back('{mn, 5, -5});
    pos_q.push_back('{0, 0, 0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_GRAV, pick_reg());
      cfg_write(REG_MASS, pick_reg());
      cfg_write(REG_SOFT, (ph % 3 == 0) ? '0 : pick_reg());
      for (int n = 0; n < ((ph == 3) ? 200 : 63); n++) begin
        if ($urandom_range(0, 19) == 0) pos_q.push_back('{0, 0, 0});
        else pos_q.push_back('{pick_coord(), pick_coord(), pick_coord()});
      end
      drain();
    end

    $display("checked %0d result beats over 12 register settings", res_cnt);
    $display("%0d zero-denominator and %0d saturated results", dz_cnt, sat_cnt);
    if (err_cnt == 0 && field_q.size() == 0) begin
      $display("[plummer_softened_gravity] OK");
    end else begin
      $display("[plummer_softened_gravity] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[plummer_softened_gravity] ERROR");
    $finish;
  end

endmodule
